// File: src/qsp_pkg.sv
// ----------------------------------------------------------------------------
// qsp_pkg
// Shared types, character codes and helper functions for the query string
// pair parser.
// ----------------------------------------------------------------------------
package qsp_pkg;

    // characters that steer the parse
    localparam logic [7:0] CHAR_PERCENT = 8'h25;
    localparam logic [7:0] CHAR_PLUS    = 8'h2B;
    localparam logic [7:0] CHAR_AMP     = 8'h26;
    localparam logic [7:0] CHAR_EQUALS  = 8'h3D;
    localparam logic [7:0] CHAR_W       = 8'h57;
    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_SPACE   = 8'h20;

    // result kinds
    localparam logic [1:0] KIND_NAME  = 2'd0;
    localparam logic [1:0] KIND_VALUE = 2'd1;
    localparam logic [1:0] KIND_END   = 2'd2;

    // pending escape counts
    localparam logic [1:0] PEND_NONE    = 2'd0;
    localparam logic [1:0] PEND_PERCENT = 2'd1;
    localparam logic [1:0] PEND_DIGIT   = 2'd2;

    // register index of plus_as_space (taken from paddr bit 2)
    localparam logic REG_PLUS_AS_SPACE = 1'b0;

    localparam int MAX_RESULTS = 4;

    typedef struct packed {
        logic [7:0] data;
        logic [1:0] kind;
        logic       done;
    } result_t;

    // all results caused by one input byte
    typedef struct packed {
        logic [2:0]                    count;
        result_t [MAX_RESULTS-1:0]     ent;
    } batch_t;

    function automatic logic is_hex(input logic [7:0] c);
        return ((c >= 8'h30) && (c <= 8'h39)) ||
               ((c >= 8'h61) && (c <= 8'h66)) ||
               ((c >= 8'h41) && (c <= 8'h46));
    endfunction

    function automatic logic [3:0] hex_val(input logic [7:0] c);
        logic [7:0] lc;
        logic [7:0] d;
        lc = c;
        if ((c >= 8'h41) && (c <= 8'h46)) begin
            lc = c + 8'd32;
        end
        if ((lc >= 8'h30) && (lc <= 8'h39)) begin
            d = lc - CHAR_ZERO;
        end else begin
            d = lc - CHAR_W;
        end
        return d[3:0];
    endfunction

endpackage

// File: src/qsp_decode.sv
// ----------------------------------------------------------------------------
// qsp_decode
// Parse state and the single-pass decode of one byte into its result batch.
// ----------------------------------------------------------------------------
module qsp_decode (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            in_fire,
    input  logic [7:0]      in_byte,
    input  logic            end_of_query,
    input  logic            plus_as_space,
    output qsp_pkg::batch_t batch
);

    logic       value_reg, value_next;
    logic [1:0] pcount_reg, pcount_next;
    logic [7:0] pdigit_reg, pdigit_next;

    // decode of the current byte against the parse state
    always_comb begin
        logic [2:0]    n;
        logic          closed;
        logic          hex;
        qsp_pkg::batch_t b;
        b           = '0;
        n           = 3'd0;
        closed      = 1'b0;
        hex         = qsp_pkg::is_hex(in_byte);
        value_next  = value_reg;
        pcount_next = pcount_reg;
        pdigit_next = pdigit_reg;

        if (!value_reg) begin
            if (in_byte == qsp_pkg::CHAR_AMP) begin
                b.ent[n[1:0]] = '{8'd0, qsp_pkg::KIND_END, end_of_query};
                n = n + 3'd1;
                closed = 1'b1;
            end else if (in_byte == qsp_pkg::CHAR_EQUALS) begin
                value_next = 1'b1;
            end else begin
                b.ent[n[1:0]] = '{in_byte, qsp_pkg::KIND_NAME, 1'b0};
                n = n + 3'd1;
            end
        end else if (pcount_reg == qsp_pkg::PEND_PERCENT && hex) begin
            pcount_next = qsp_pkg::PEND_DIGIT;
            pdigit_next = in_byte;
        end else if (pcount_reg == qsp_pkg::PEND_DIGIT && hex) begin
            b.ent[n[1:0]] = '{{qsp_pkg::hex_val(pdigit_reg), qsp_pkg::hex_val(in_byte)},
                              qsp_pkg::KIND_VALUE, 1'b0};
            n = n + 3'd1;
            pcount_next = qsp_pkg::PEND_NONE;
            pdigit_next = 8'd0;
        end else begin
            // broken escape goes out literally
            if (pcount_reg != qsp_pkg::PEND_NONE) begin
                b.ent[n[1:0]] = '{qsp_pkg::CHAR_PERCENT, qsp_pkg::KIND_VALUE, 1'b0};
                n = n + 3'd1;
            end
            if (pcount_reg == qsp_pkg::PEND_DIGIT) begin
                b.ent[n[1:0]] = '{pdigit_reg, qsp_pkg::KIND_VALUE, 1'b0};
                n = n + 3'd1;
            end
            pcount_next = qsp_pkg::PEND_NONE;
            pdigit_next = 8'd0;
            if (in_byte == qsp_pkg::CHAR_AMP) begin
                b.ent[n[1:0]] = '{8'd0, qsp_pkg::KIND_END, end_of_query};
                n = n + 3'd1;
                closed = 1'b1;
            end else if (in_byte == qsp_pkg::CHAR_PERCENT) begin
                pcount_next = qsp_pkg::PEND_PERCENT;
            end else if (plus_as_space && in_byte == qsp_pkg::CHAR_PLUS) begin
                b.ent[n[1:0]] = '{qsp_pkg::CHAR_SPACE, qsp_pkg::KIND_VALUE, 1'b0};
                n = n + 3'd1;
            end else begin
                b.ent[n[1:0]] = '{in_byte, qsp_pkg::KIND_VALUE, 1'b0};
                n = n + 3'd1;
            end
        end

        // end of query: flush what is left and close the pair
        if (end_of_query && !closed) begin
            if (pcount_next != qsp_pkg::PEND_NONE) begin
                b.ent[n[1:0]] = '{qsp_pkg::CHAR_PERCENT, qsp_pkg::KIND_VALUE, 1'b0};
                n = n + 3'd1;
            end
            if (pcount_next == qsp_pkg::PEND_DIGIT) begin
                b.ent[n[1:0]] = '{pdigit_next, qsp_pkg::KIND_VALUE, 1'b0};
                n = n + 3'd1;
            end
            b.ent[n[1:0]] = '{8'd0, qsp_pkg::KIND_END, 1'b1};
            n = n + 3'd1;
            closed = 1'b1;
        end

        if (closed) begin
            value_next  = 1'b0;
            pcount_next = qsp_pkg::PEND_NONE;
            pdigit_next = 8'd0;
        end

        b.count = n;
        batch   = b;
    end

    // parse state advances on each accepted byte
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            value_reg  <= 1'b0;
            pcount_reg <= qsp_pkg::PEND_NONE;
            pdigit_reg <= 8'd0;
        end else if (in_fire) begin
            value_reg  <= value_next;
            pcount_reg <= pcount_next;
            pdigit_reg <= pdigit_next;
        end
    end

endmodule

// File: src/qsp_emit.sv
// ----------------------------------------------------------------------------
// qsp_emit
// Result register: holds the batch of one byte and hands it out one result
// per transfer.
// ----------------------------------------------------------------------------
module qsp_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            load,
    input  qsp_pkg::batch_t batch,
    output logic            room,
    output logic            m_valid,
    input  logic            m_ready,
    output qsp_pkg::result_t m_res,
    output logic            m_run_last
);

    logic [2:0]                                 cnt_reg, cnt_next;
    qsp_pkg::result_t [qsp_pkg::MAX_RESULTS-1:0] ent_reg, ent_next;
    logic                                       take;

    assign m_valid    = (cnt_reg != 3'd0);
    assign take       = m_valid && m_ready;
    assign m_res      = ent_reg[0];
    assign m_run_last = (cnt_reg == 3'd1);
    // a new batch fits once the held one is gone or leaves this cycle
    assign room       = (cnt_reg == 3'd0) || ((cnt_reg == 3'd1) && m_ready);

    // load a new batch or shift the held one down
    always_comb begin
        cnt_next = cnt_reg;
        ent_next = ent_reg;
        if (load) begin
            cnt_next = batch.count;
            ent_next = batch.ent;
        end else if (take) begin
            cnt_next = cnt_reg - 3'd1;
            for (int i = 0; i < qsp_pkg::MAX_RESULTS - 1; i++) begin
                ent_next[i] = ent_reg[i+1];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg <= ent_next;
    end

endmodule

// File: src/query_string_pair_parser.sv
// ----------------------------------------------------------------------------
// query_string_pair_parser
// Splits a query string into name/value pairs and percent-decodes values.
// ----------------------------------------------------------------------------
//  channel   direction  payload
//  s_axis    in         tdata = in_byte, tlast = end_of_query
//  m_axis    out        tdata = out_byte, tuser = out_kind/run_last, tlast = query_done
//  apb       in/out     plus_as_space at byte address 0
//
// A byte is decoded in the cycle it is accepted and its results land in the
// result register; they leave one per cycle unless the output stalls. A byte
// with several results holds the input until its last one leaves; bytes go
// in one per cycle while each gives at most one result; else the output paces.
// Reset is synchronous: parse state back to the name part, result register
// empty, plus_as_space cleared. Output stalls back up into s_axis_tready.
// ----------------------------------------------------------------------------
module query_string_pair_parser (
    input  logic       aclk,
    input  logic       aresetn,
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] in_byte
    input  logic       s_axis_tlast,
    // result stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [7:0] out_byte
    output logic [2:0] m_axis_tuser,   // [1:0] out_kind, [2] run_last
    output logic       m_axis_tlast,   // query_done
    // configuration
    input  logic       psel,
    input  logic       penable,
    input  logic       pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic       pready
);

    logic             plus_reg;
    logic             s_fire;
    logic             room;
    logic             run_last;
    qsp_pkg::batch_t  batch;
    qsp_pkg::result_t res;

    // configuration register
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            plus_reg <= 1'b0;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == qsp_pkg::REG_PLUS_AS_SPACE) begin
            plus_reg <= pwdata[0];
        end
    end
    assign prdata = (paddr[2] == qsp_pkg::REG_PLUS_AS_SPACE) ? {31'd0, plus_reg} : 32'd0;

    assign s_axis_tready = room;
    assign s_fire        = s_axis_tvalid && s_axis_tready;

    qsp_decode u_decode (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_fire       (s_fire),
        .in_byte       (s_axis_tdata),
        .end_of_query  (s_axis_tlast),
        .plus_as_space (plus_reg),
        .batch         (batch)
    );

    qsp_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .load       (s_fire),
        .batch      (batch),
        .room       (room),
        .m_valid    (m_axis_tvalid),
        .m_ready    (m_axis_tready),
        .m_res      (res),
        .m_run_last (run_last)
    );

    assign m_axis_tdata = res.data;
    assign m_axis_tuser = {run_last, res.kind};
    assign m_axis_tlast = res.done;

    // a pair end is always the last result of its byte
    a_end_is_run_last : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tuser[1:0] == qsp_pkg::KIND_END |-> m_axis_tuser[2])
        else $error("pair end not marked as last result of its byte");

    // query close only on a pair end
    a_done_on_end : assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser[1:0] == qsp_pkg::KIND_END)
        else $error("query_done on a result that is not a pair end");

    // an input transfer never overwrites a result still waiting
    a_no_overrun : assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire && m_axis_tvalid |-> m_axis_tready && m_axis_tuser[2])
        else $error("input accepted over a pending result");

endmodule
